@@ rtl/i2cbm_pkg.sv @@
package i2cbm_pkg;

	localparam logic [2:0] ACT_NOP   = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_STOP  = 3'd2;
	localparam logic [2:0] ACT_WRITE = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;
	localparam logic [2:0] ACT_CLEAR = 3'd5;

	localparam logic [1:0] CFG_HALF    = 2'd0;
	localparam logic [1:0] CFG_QUARTER = 2'd1;
	localparam logic [1:0] CFG_STRETCH = 2'd2;
	localparam logic [1:0] CFG_CLEAR   = 2'd3;

	localparam logic [7:0]  HALF_RST    = 8'd4;
	localparam logic [7:0]  QUARTER_RST = 8'd4;
	localparam logic [7:0]  STRETCH_RST = 8'd255;
	localparam logic [15:0] CLEAR_RST   = 16'd10;

	localparam logic [3:0] CLEAR_PULSES = 4'd9;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       scl_in;
		logic       sda_in;
	} cmd_item_t;

	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       slave_acked;
	} rsp_item_t;

	typedef struct packed {
		logic [7:0]  half_period_ticks;
		logic [7:0]  quarter_period_ticks;
		logic [7:0]  stretch_limit;
		logic [15:0] clear_step_ticks;
	} cfg_regs_t;

endpackage

@@ rtl/i2cbm_if.sv @@
interface i2cbm_cmd_if;
	import i2cbm_pkg::*;
	logic      valid;
	logic      ready;
	cmd_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cbm_rsp_if;
	import i2cbm_pkg::*;
	logic      valid;
	logic      ready;
	rsp_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cbm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/i2cbm_cfg.sv @@
module i2cbm_cfg
	import i2cbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data,
	output cfg_regs_t   regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.half_period_ticks    <= HALF_RST;
			regs_q.quarter_period_ticks <= QUARTER_RST;
			regs_q.stretch_limit        <= STRETCH_RST;
			regs_q.clear_step_ticks     <= CLEAR_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_HALF:    regs_q.half_period_ticks    <= wr_data[7:0];
				CFG_QUARTER: regs_q.quarter_period_ticks <= wr_data[7:0];
				CFG_STRETCH: regs_q.stretch_limit        <= wr_data[7:0];
				CFG_CLEAR:   regs_q.clear_step_ticks     <= wr_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

@@ rtl/i2cbm_step.sv @@
module i2cbm_step
	import i2cbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  cmd_item_t item,
	input  cfg_regs_t regs,
	output rsp_item_t result
);

	typedef enum logic [4:0] {
		PH_IDLE, ST_STR, ST_H1, ST_H2, SP_H1, SP_STR, SP_H2, SP_H3,
		B_LOW, B_STR, B_Q, A_LOW, A_STR, A_TAIL,
		C_SDA, C_SCL, C_PLOW, C_PSTR, C_PHIGH, C_SDA1, C_STR2, C_H2,
		C_SDA2, C_SCL2, C_STR3, C_H3, C_END
	} phase_t;

	phase_t      phase_q, n_phase, go_ph;
	logic [3:0]  bit_q, n_bit;
	logic [7:0]  shift_q, n_shift;
	logic [15:0] wait_q, n_wait;
	logic [7:0]  str_q, n_str;
	logic        ack_q, n_ack;
	logic [7:0]  rx_q, n_rx;
	logic        scl_low_q, n_scl_low;
	logic        sda_low_q, n_sda_low;
	logic        reading_q, n_reading;
	logic        ack_hold_q, n_ack_hold;
	logic        done_q, n_done;
	logic        go_en, is_str, dly_done, str_done;
	logic [7:0]  str_inc;

	assign dly_done = (wait_q <= 16'd1);
	assign str_inc  = str_q + 8'd1;
	assign str_done = item.scl_in || (str_inc >= regs.stretch_limit);
	assign is_str   = (phase_q == ST_STR) || (phase_q == SP_STR) || (phase_q == B_STR) ||
	                  (phase_q == A_STR) || (phase_q == C_PSTR) || (phase_q == C_STR2) ||
	                  (phase_q == C_STR3);

	always_comb begin
		n_phase    = phase_q;
		n_bit      = bit_q;
		n_shift    = shift_q;
		n_wait     = wait_q;
		n_str      = str_q;
		n_ack      = ack_q;
		n_rx       = rx_q;
		n_scl_low  = scl_low_q;
		n_sda_low  = sda_low_q;
		n_reading  = reading_q;
		n_ack_hold = ack_hold_q;
		n_done     = 1'b0;
		go_en      = 1'b0;
		go_ph      = PH_IDLE;

		if (phase_q == PH_IDLE) begin
			case (item.action)
				ACT_START: begin
					go_en = 1'b1; go_ph = ST_STR;
				end
				ACT_STOP: begin
					go_en = 1'b1; go_ph = SP_H1;
				end
				ACT_WRITE: begin
					n_reading = 1'b0;
					n_shift   = item.tx_byte;
					n_bit     = 4'd7;
					go_en     = 1'b1; go_ph = B_LOW;
				end
				ACT_READ: begin
					n_reading  = 1'b1;
					n_ack_hold = item.send_ack;
					n_shift    = 8'd0;
					n_bit      = 4'd7;
					go_en      = 1'b1; go_ph = B_LOW;
				end
				ACT_CLEAR: begin
					n_bit = 4'd0;
					go_en = 1'b1; go_ph = C_SDA;
				end
				default: ;
			endcase
		end else begin
			if (is_str) begin
				if (!item.scl_in) n_str = str_inc;
			end else if (!dly_done) begin
				n_wait = wait_q - 16'd1;
			end

			unique case (phase_q)
				ST_STR:  if (str_done) begin go_en = 1'b1; go_ph = ST_H1; end
				ST_H1:   if (dly_done) begin go_en = 1'b1; go_ph = ST_H2; end
				SP_H1:   if (dly_done) begin go_en = 1'b1; go_ph = SP_STR; end
				SP_STR:  if (str_done) begin go_en = 1'b1; go_ph = SP_H2; end
				SP_H2:   if (dly_done) begin go_en = 1'b1; go_ph = SP_H3; end
				B_LOW:   if (dly_done) begin go_en = 1'b1; go_ph = B_STR; end
				B_STR: begin
					if (str_done) begin
						if (reading_q && item.sda_in) n_shift[bit_q[2:0]] = 1'b1;
						go_en = 1'b1; go_ph = B_Q;
					end
				end
				B_Q: begin
					if (dly_done) begin
						go_en = 1'b1;
						if (bit_q[2:0] == 3'd0) begin
							go_ph = A_LOW;
						end else begin
							n_bit = {1'b0, bit_q[2:0] - 3'd1};
							go_ph = B_LOW;
						end
					end
				end
				A_LOW:   if (dly_done) begin go_en = 1'b1; go_ph = A_STR; end
				A_STR: begin
					if (str_done) begin
						if (!reading_q) n_ack = !item.sda_in;
						go_en = 1'b1; go_ph = A_TAIL;
					end
				end
				A_TAIL: begin
					if (dly_done) begin
						if (reading_q) n_rx = shift_q;
						n_done = 1'b1;
					end
				end
				C_SDA:   if (dly_done) begin go_en = 1'b1; go_ph = C_SCL; end
				C_SCL:   if (dly_done) begin go_en = 1'b1; go_ph = C_PLOW; end
				C_PLOW:  if (dly_done) begin go_en = 1'b1; go_ph = C_PSTR; end
				C_PSTR:  if (str_done) begin go_en = 1'b1; go_ph = C_PHIGH; end
				C_PHIGH: begin
					if (dly_done) begin
						n_bit = bit_q + 4'd1;
						go_en = 1'b1;
						go_ph = (n_bit >= CLEAR_PULSES) ? C_SDA1 : C_PLOW;
					end
				end
				C_SDA1:  if (dly_done) begin go_en = 1'b1; go_ph = C_STR2; end
				C_STR2:  if (str_done) begin go_en = 1'b1; go_ph = C_H2; end
				C_H2:    if (dly_done) begin go_en = 1'b1; go_ph = C_SDA2; end
				C_SDA2:  if (dly_done) begin go_en = 1'b1; go_ph = C_SCL2; end
				C_SCL2:  if (dly_done) begin go_en = 1'b1; go_ph = C_STR3; end
				C_STR3:  if (str_done) begin go_en = 1'b1; go_ph = C_H3; end
				C_H3:    if (dly_done) begin go_en = 1'b1; go_ph = C_END; end
				ST_H2, SP_H3, C_END: if (dly_done) n_done = 1'b1;
				default: n_done = 1'b1;
			endcase
		end

		// phase entry actions
		if (go_en) begin
			n_phase = go_ph;
			n_str   = 8'd0;
			n_wait  = regs.clear_step_ticks;
			case (go_ph)
				ST_STR, SP_STR, B_STR, A_STR, C_PSTR, C_STR2, C_STR3: begin
					n_scl_low = 1'b0;
					n_wait    = 16'd0;
				end
				ST_H1, SP_H2: n_wait = {8'd0, regs.half_period_ticks};
				ST_H2: begin
					n_sda_low = 1'b1;
					n_wait    = {8'd0, regs.half_period_ticks};
				end
				SP_H1: begin
					n_scl_low = 1'b1;
					n_sda_low = 1'b1;
					n_wait    = {8'd0, regs.half_period_ticks};
				end
				SP_H3: begin
					n_sda_low = 1'b0;
					n_wait    = {8'd0, regs.half_period_ticks};
				end
				B_LOW: begin
					n_scl_low = 1'b1;
					n_sda_low = !n_reading && !n_shift[n_bit[2:0]];
					n_wait    = {8'd0, regs.half_period_ticks};
				end
				B_Q: n_wait = {8'd0, regs.quarter_period_ticks};
				A_LOW: begin
					n_scl_low = 1'b1;
					n_sda_low = n_reading && n_ack_hold;
					n_wait    = {8'd0, regs.half_period_ticks};
				end
				A_TAIL: n_wait = n_reading ? {8'd0, regs.half_period_ticks}
				                           : {8'd0, regs.quarter_period_ticks};
				C_SDA, C_SDA2: n_sda_low = 1'b1;
				C_SCL, C_PLOW, C_SCL2: n_scl_low = 1'b1;
				C_SDA1, C_END: n_sda_low = 1'b0;
				default: ;
			endcase
		end

		if (n_done) begin
			n_phase = PH_IDLE;
			n_wait  = 16'd0;
			n_str   = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_q      <= 4'd0;
			shift_q    <= 8'd0;
			wait_q     <= 16'd0;
			str_q      <= 8'd0;
			ack_q      <= 1'b0;
			rx_q       <= 8'd0;
			scl_low_q  <= 1'b0;
			sda_low_q  <= 1'b0;
			reading_q  <= 1'b0;
			ack_hold_q <= 1'b0;
			done_q     <= 1'b0;
		end else if (en) begin
			phase_q    <= n_phase;
			bit_q      <= n_bit;
			shift_q    <= n_shift;
			wait_q     <= n_wait;
			str_q      <= n_str;
			ack_q      <= n_ack;
			rx_q       <= n_rx;
			scl_low_q  <= n_scl_low;
			sda_low_q  <= n_sda_low;
			reading_q  <= n_reading;
			ack_hold_q <= n_ack_hold;
			done_q     <= n_done;
		end
	end

	assign result.scl_drive_low = scl_low_q;
	assign result.sda_drive_low = sda_low_q;
	assign result.busy_res      = (phase_q != PH_IDLE);
	assign result.done_res      = done_q;
	assign result.rx_byte       = rx_q;
	assign result.slave_acked   = ack_q;

endmodule

@@ rtl/i2c_byte_master.sv @@
// Byte-level I2C master, one request per timebase tick while rsp does not stall.
// Flow: an accepted request is held in the input register, then stepped into
// the state registers (waiting while rsp stalls); its result is valid after it.
// Throughput: one request per cycle while rsp does not stall; the single state update step sets it.
// Reset: arst_n clears the state to idle with both lines released and loads
// the register defaults (half 4, quarter 4, stretch limit 255, clear step 10).
module i2c_byte_master
	import i2cbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	i2cbm_cmd_if.sink   cmd,
	i2cbm_rsp_if.source rsp,
	i2cbm_cfg_if.sink   cfg
);

	cmd_item_t item_s1;
	logic      valid_s1;
	logic      out_valid_q;
	logic      advance;
	cfg_regs_t regs;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) item_s1 <= cmd.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	i2cbm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.regs     (regs)
	);

	i2cbm_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.regs   (regs),
		.result (rsp.data)
	);

	assign rsp.valid = out_valid_q;

endmodule
